>>> rtl/psvn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psvn_pkg;

  localparam int unsigned MaxPoints = 64;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned VecW      = 34;
  localparam int unsigned NrmW      = 16;

  typedef enum logic [3:0] {
    ST_LOAD, ST_RCUR, ST_RPREV, ST_RNEXT, ST_CAPT,
    ST_GOA, ST_WA, ST_GOB, ST_WB, ST_GOS, ST_WS, ST_OUT
  } top_state_e;

  typedef enum logic [2:0] {
    U_IDLE, U_SHIFT, U_SQX, U_SQY, U_ADD, U_SQRT, U_DINIT, U_DIV
  } unit_state_e;

  typedef struct packed {
    logic                   start;
    logic signed [VecW-1:0] vx;
    logic signed [VecW-1:0] vy;
  } nrm_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [NrmW-1:0] nx;
    logic signed [NrmW-1:0] ny;
  } nrm_rsp_t;

endpackage

`default_nettype wire

>>> rtl/psvn_store.sv
`timescale 1ns / 1ps
`default_nettype none

module psvn_store (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [psvn_pkg::IdxW-1:0]  waddr_i,
  input  wire logic [63:0]                wdata_i,
  input  wire logic [psvn_pkg::IdxW-1:0]  raddr_i,
  output logic      [63:0]                rdata_o
);

  logic [63:0] mem [psvn_pkg::MaxPoints];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/psvn_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module psvn_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire psvn_pkg::nrm_req_t req_i,
  output psvn_pkg::nrm_rsp_t      rsp_o
);

  psvn_pkg::unit_state_e state_q, state_d;

  logic [32:0] ax_q, ay_q;
  logic        sx_q, sy_q, zero_q;
  logic [59:0] prod_q;
  logic [61:0] s_q;
  logic [32:0] rem_q;
  logic [30:0] root_q;
  logic [4:0]  cnt_q;
  logic [30:0] remx_q, remy_q;
  logic [14:0] lowx_q, lowy_q;
  logic [14:0] qx_q, qy_q;
  logic        fin_q;

  logic [33:0] absx, absy;
  logic [32:0] m;
  logic        m_hi, m_lo;
  logic [34:0] remt, trial;
  logic [44:0] numx, numy;
  logic [31:0] tx, ty, lext;

  assign absx  = req_i.vx[33] ? 34'(-req_i.vx) : 34'(req_i.vx);
  assign absy  = req_i.vy[33] ? 34'(-req_i.vy) : 34'(req_i.vy);
  assign m     = (ax_q > ay_q) ? ax_q : ay_q;
  assign m_hi  = |m[32:30];
  assign m_lo  = ~|m[32:29];
  assign remt  = {rem_q, s_q[61:60]};
  assign trial = {2'b00, root_q, 2'b01};
  assign numx  = {ax_q[29:0], 15'd0} - 45'({ax_q[29:0], 14'd0}) + 45'(root_q >> 1);
  assign numy  = {ay_q[29:0], 15'd0} - 45'({ay_q[29:0], 14'd0}) + 45'(root_q >> 1);
  assign lext  = {1'b0, root_q};
  assign tx    = {remx_q, lowx_q[14]};
  assign ty    = {remy_q, lowy_q[14]};

  always_comb begin
    state_d = state_q;
    case (state_q)
      psvn_pkg::U_IDLE:  if (req_i.start) begin
        state_d = ((absx == '0) && (absy == '0)) ? psvn_pkg::U_IDLE : psvn_pkg::U_SHIFT;
      end
      psvn_pkg::U_SHIFT: if (!m_hi && !m_lo) state_d = psvn_pkg::U_SQX;
      psvn_pkg::U_SQX:   state_d = psvn_pkg::U_SQY;
      psvn_pkg::U_SQY:   state_d = psvn_pkg::U_ADD;
      psvn_pkg::U_ADD:   state_d = psvn_pkg::U_SQRT;
      psvn_pkg::U_SQRT:  if (cnt_q == '0) state_d = psvn_pkg::U_DINIT;
      psvn_pkg::U_DINIT: state_d = psvn_pkg::U_DIV;
      psvn_pkg::U_DIV:   if (cnt_q == '0) state_d = psvn_pkg::U_IDLE;
      default:           state_d = psvn_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = fin_q;
    rsp_o.nx   = sx_q ? -$signed({1'b0, qx_q}) : $signed({1'b0, qx_q});
    rsp_o.ny   = sy_q ? -$signed({1'b0, qy_q}) : $signed({1'b0, qy_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psvn_pkg::U_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= (state_q == psvn_pkg::U_DIV && cnt_q == '0) ||
                 (state_q == psvn_pkg::U_IDLE && req_i.start &&
                  absx == '0 && absy == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      psvn_pkg::U_IDLE: begin
        ax_q <= absx[32:0];
        ay_q <= absy[32:0];
        sx_q <= req_i.vx[33];
        sy_q <= req_i.vy[33];
        qx_q <= '0;
        qy_q <= '0;
      end
      psvn_pkg::U_SHIFT: begin
        if (m_hi) begin
          ax_q <= ax_q >> 1;
          ay_q <= ay_q >> 1;
        end else if (m_lo) begin
          ax_q <= ax_q << 1;
          ay_q <= ay_q << 1;
        end
      end
      psvn_pkg::U_SQX: prod_q <= ax_q[29:0] * ax_q[29:0];
      psvn_pkg::U_SQY: begin
        s_q    <= 62'(prod_q);
        prod_q <= ay_q[29:0] * ay_q[29:0];
      end
      psvn_pkg::U_ADD: begin
        s_q    <= s_q + 62'(prod_q);
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= 5'd30;
      end
      psvn_pkg::U_SQRT: begin
        s_q   <= s_q << 2;
        cnt_q <= cnt_q - 5'd1;
        if (remt >= trial) begin
          rem_q  <= 33'(remt - trial);
          root_q <= {root_q[29:0], 1'b1};
        end else begin
          rem_q  <= remt[32:0];
          root_q <= {root_q[29:0], 1'b0};
        end
      end
      psvn_pkg::U_DINIT: begin
        remx_q <= {1'b0, numx[44:15]};
        remy_q <= {1'b0, numy[44:15]};
        lowx_q <= numx[14:0];
        lowy_q <= numy[14:0];
        cnt_q  <= 5'd14;
      end
      psvn_pkg::U_DIV: begin
        cnt_q  <= cnt_q - 5'd1;
        lowx_q <= lowx_q << 1;
        lowy_q <= lowy_q << 1;
        if (tx >= lext) begin
          remx_q <= 31'(tx - lext);
          qx_q   <= {qx_q[13:0], 1'b1};
        end else begin
          remx_q <= tx[30:0];
          qx_q   <= {qx_q[13:0], 1'b0};
        end
        if (ty >= lext) begin
          remy_q <= 31'(ty - lext);
          qy_q   <= {qy_q[13:0], 1'b1};
        end else begin
          remy_q <= ty[30:0];
          qy_q   <= {qy_q[13:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/polyline_smooth_vertex_normals.sv
// Channel | Handshake                   | Payload
// input   | in_valid_i / in_ready_o     | point_x_i, point_y_i, last_point_i
// output  | out_valid_o / out_ready_i   | vertex_x_o, vertex_y_o, normal_x_o, normal_y_o,
//         |                             | last_vertex_o, overflow_o
// config  | cfg_we_i                    | cfg_wdata_i (closed)
// An accepted point is written to the store. On the last point one vertex is emitted per stored point.
// Each vertex reads the current, previous and next points, runs up to three normalisations on
// one shared unit and is then output. A normalisation runs 0 to 29 shift steps, 31 root steps
// and 15 divide steps; a zero vector gives a zero normal with no steps.
// in_ready_o is low while a run is emitted; a stalled output holds the sequencer.
// Reset clears the point count and overflow flag; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module polyline_smooth_vertex_normals (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic               last_point_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      vertex_x_o,
  output logic signed [31:0]      vertex_y_o,
  output logic signed [15:0]      normal_x_o,
  output logic signed [15:0]      normal_y_o,
  output logic                    last_vertex_o,
  output logic                    overflow_o
);

  localparam int unsigned IdxW = psvn_pkg::IdxW;
  localparam int unsigned CntW = psvn_pkg::CntW;

  psvn_pkg::top_state_e state_q, state_d;

  logic            closed_q, dropped_q, out_valid_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] k_q;
  logic [31:0]     cx_q, cy_q, px_q, py_q, qx_q, qy_q;
  logic signed [15:0] nax_q, nay_q, nbx_q, nby_q, nox, noy;

  logic            in_acc, wr_en, room, is_last, has_a, has_b, slot_free;
  logic [IdxW-1:0] raddr, prev_idx, next_idx;
  logic [CntW-1:0] nm1;
  logic [63:0]     rdata;
  logic signed [32:0] dx, dy;
  psvn_pkg::nrm_req_t req;
  psvn_pkg::nrm_rsp_t rsp;

  psvn_store u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i ({point_y_i, point_x_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  psvn_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign room      = count_q < CntW'(psvn_pkg::MaxPoints);
  assign in_acc    = in_valid_i && in_ready_o;
  assign wr_en     = in_acc && room;
  assign nm1       = count_q - CntW'(1);
  assign is_last   = {1'b0, k_q} == nm1;
  assign prev_idx  = (k_q == '0) ? nm1[IdxW-1:0] : k_q - IdxW'(1);
  assign next_idx  = is_last ? '0 : k_q + IdxW'(1);
  assign has_a     = (count_q >= CntW'(2)) && (closed_q || k_q != '0);
  assign has_b     = (count_q >= CntW'(2)) && (closed_q || !is_last);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      psvn_pkg::ST_LOAD:  if (in_acc && last_point_i) state_d = psvn_pkg::ST_RCUR;
      psvn_pkg::ST_RCUR:  state_d = psvn_pkg::ST_RPREV;
      psvn_pkg::ST_RPREV: state_d = psvn_pkg::ST_RNEXT;
      psvn_pkg::ST_RNEXT: state_d = psvn_pkg::ST_CAPT;
      psvn_pkg::ST_CAPT:  state_d = psvn_pkg::ST_GOA;
      psvn_pkg::ST_GOA:   state_d = has_a ? psvn_pkg::ST_WA : psvn_pkg::ST_GOB;
      psvn_pkg::ST_WA:    if (rsp.done) state_d = psvn_pkg::ST_GOB;
      psvn_pkg::ST_GOB:   state_d = has_b ? psvn_pkg::ST_WB : psvn_pkg::ST_GOS;
      psvn_pkg::ST_WB:    if (rsp.done) state_d = psvn_pkg::ST_GOS;
      psvn_pkg::ST_GOS:   state_d = (has_a && has_b) ? psvn_pkg::ST_WS : psvn_pkg::ST_OUT;
      psvn_pkg::ST_WS:    if (rsp.done) state_d = psvn_pkg::ST_OUT;
      psvn_pkg::ST_OUT: begin
        if (slot_free) state_d = is_last ? psvn_pkg::ST_LOAD : psvn_pkg::ST_RCUR;
      end
      default:            state_d = psvn_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o = state_q == psvn_pkg::ST_LOAD;
    case (state_q)
      psvn_pkg::ST_RPREV: raddr = prev_idx;
      psvn_pkg::ST_RNEXT: raddr = next_idx;
      default:            raddr = k_q;
    endcase
    if (state_q == psvn_pkg::ST_GOB) begin
      dx = $signed({qx_q[31], qx_q}) - $signed({cx_q[31], cx_q});
      dy = $signed({qy_q[31], qy_q}) - $signed({cy_q[31], cy_q});
    end else begin
      dx = $signed({cx_q[31], cx_q}) - $signed({px_q[31], px_q});
      dy = $signed({cy_q[31], cy_q}) - $signed({py_q[31], py_q});
    end
    req.start = (state_q == psvn_pkg::ST_GOA && has_a) ||
                (state_q == psvn_pkg::ST_GOB && has_b) ||
                (state_q == psvn_pkg::ST_GOS && has_a && has_b);
    if (state_q == psvn_pkg::ST_GOS) begin
      req.vx = 34'(nax_q) + 34'(nbx_q);
      req.vy = 34'(nay_q) + 34'(nby_q);
    end else begin
      req.vx = -34'(dy);
      req.vy = 34'(dx);
    end
    if (has_a && has_b) begin
      nox = rsp.nx;
      noy = rsp.ny;
    end else if (has_a) begin
      nox = nax_q;
      noy = nay_q;
    end else if (has_b) begin
      nox = nbx_q;
      noy = nby_q;
    end else begin
      nox = '0;
      noy = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psvn_pkg::ST_LOAD;
      closed_q    <= 1'b0;
      dropped_q   <= 1'b0;
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) closed_q <= cfg_wdata_i;
      if (wr_en) count_q <= count_q + CntW'(1);
      if (in_acc && !room) dropped_q <= 1'b1;
      if (in_acc && last_point_i) k_q <= '0;
      if (state_q == psvn_pkg::ST_OUT && slot_free) begin
        out_valid_q <= 1'b1;
        k_q         <= k_q + IdxW'(1);
        if (is_last) begin
          count_q   <= '0;
          dropped_q <= 1'b0;
        end
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      psvn_pkg::ST_RPREV: {cy_q, cx_q} <= rdata;
      psvn_pkg::ST_RNEXT: {py_q, px_q} <= rdata;
      psvn_pkg::ST_CAPT:  {qy_q, qx_q} <= rdata;
      psvn_pkg::ST_WA: if (rsp.done) begin
        nax_q <= rsp.nx;
        nay_q <= rsp.ny;
      end
      psvn_pkg::ST_WB: if (rsp.done) begin
        nbx_q <= rsp.nx;
        nby_q <= rsp.ny;
      end
      psvn_pkg::ST_WS: if (rsp.done) begin
        nax_q <= rsp.nx;
        nay_q <= rsp.ny;
      end
      psvn_pkg::ST_OUT: if (slot_free) begin
        vertex_x_o    <= cx_q;
        vertex_y_o    <= cy_q;
        normal_x_o    <= (has_a && has_b) ? nax_q : nox;
        normal_y_o    <= (has_a && has_b) ? nay_q : noy;
        last_vertex_o <= is_last;
        overflow_o    <= dropped_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(psvn_pkg::MaxPoints))
    else $error("point count beyond store depth");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == psvn_pkg::ST_WA || state_q == psvn_pkg::ST_WB ||
                  state_q == psvn_pkg::ST_WS))
    else $error("normaliser result with no waiting request");

  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_point_i |=> state_q == psvn_pkg::ST_RCUR && count_q != '0)
    else $error("run did not start after last point");

  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != psvn_pkg::ST_LOAD |-> count_q != '0)
    else $error("emitting an empty run");

endmodule

`default_nettype wire

>>> test/tb_polyline_smooth_vertex_normals.sv
`timescale 1ns / 1ps

module tb_polyline_smooth_vertex_normals;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainWait  = 400;
  localparam int unsigned RandPoints = 260;

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic               last;
    logic               ovf;
  } vertex_t;

  class normal_tracker;
    logic signed [31:0] px[psvn_pkg::MaxPoints];
    logic signed [31:0] py[psvn_pkg::MaxPoints];
    int unsigned        count;
    bit                 dropped;
    bit                 closed;
    vertex_t            pending[$];
    int unsigned        errors;

    function automatic longint unsigned root_floor(longint unsigned s);
      longint unsigned res, bits;
      res  = 0;
      bits = 64'd1 << 62;
      while (bits > s) bits >>= 2;
      while (bits != 0) begin
        if (s >= res + bits) begin
          s   -= res + bits;
          res  = (res >> 1) + bits;
        end else begin
          res >>= 1;
        end
        bits >>= 2;
      end
      return res;
    endfunction

    function automatic void unit_vec(input longint vx, input longint vy,
                                     output longint ox, output longint oy);
      longint unsigned ax, ay, m, len, qx, qy;
      ax = (vx < 0) ? -vx : vx;
      ay = (vy < 0) ? -vy : vy;
      m  = (ax > ay) ? ax : ay;
      if (m == 0) begin
        ox = 0;
        oy = 0;
        return;
      end
      while (m >= (64'd1 << 30)) begin
        m >>= 1; ax >>= 1; ay >>= 1;
      end
      while (m < (64'd1 << 29)) begin
        m <<= 1; ax <<= 1; ay <<= 1;
      end
      len = root_floor(ax * ax + ay * ay);
      qx  = (ax * 16384 + len / 2) / len;
      qy  = (ay * 16384 + len / 2) / len;
      ox  = (vx < 0) ? -longint'(qx) : longint'(qx);
      oy  = (vy < 0) ? -longint'(qy) : longint'(qy);
    endfunction

    function automatic void seg_dir(input int unsigned a, input int unsigned b,
                                    output longint nx, output longint ny);
      longint dx, dy;
      dx = longint'(px[b]) - longint'(px[a]);
      dy = longint'(py[b]) - longint'(py[a]);
      unit_vec(-dy, dx, nx, ny);
    endfunction

    function automatic void corner_dir(input int unsigned a, input int unsigned b,
                                       input int unsigned c,
                                       output longint nx, output longint ny);
      longint x1, y1, x2, y2;
      seg_dir(a, b, x1, y1);
      seg_dir(b, c, x2, y2);
      unit_vec(x1 + x2, y1 + y2, nx, ny);
    endfunction

    function void take_point(logic signed [31:0] x, logic signed [31:0] y, logic last);
      vertex_t v;
      longint  nx, ny;
      if (count < psvn_pkg::MaxPoints) begin
        px[count] = x;
        py[count] = y;
        count++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      for (int unsigned k = 0; k < count; k++) begin
        nx = 0;
        ny = 0;
        if (count >= 2) begin
          if (k > 0 && k < count - 1) corner_dir(k - 1, k, k + 1, nx, ny);
          else if (closed) corner_dir(k == 0 ? count - 1 : k - 1, k, k == 0 ? 1 : 0, nx, ny);
          else if (k == 0) seg_dir(0, 1, nx, ny);
          else seg_dir(count - 2, count - 1, nx, ny);
        end
        v.vx   = px[k];
        v.vy   = py[k];
        v.nx   = nx[15:0];
        v.ny   = ny[15:0];
        v.last = (k == count - 1);
        v.ovf  = dropped;
        pending.push_back(v);
      end
      count   = 0;
      dropped = 0;
    endfunction

    function void field_cmp(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_vertex(vertex_t a);
      vertex_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected vertex, expected none actual x=%0d y=%0d",
                 $time, a.vx, a.vy);
        errors++;
        return;
      end
      e = pending.pop_front();
      field_cmp("vertex_x", e.vx, a.vx);
      field_cmp("vertex_y", e.vy, a.vy);
      field_cmp("normal_x", e.nx, a.nx);
      field_cmp("normal_y", e.ny, a.ny);
      field_cmp("last_vertex", e.last, a.last);
      field_cmp("overflow", e.ovf, a.ovf);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] point_x_i;
  logic signed [31:0] point_y_i;
  logic               last_point_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] vertex_x_o;
  logic signed [31:0] vertex_y_o;
  logic signed [15:0] normal_x_o;
  logic signed [15:0] normal_y_o;
  logic               last_vertex_o;
  logic               overflow_o;

  normal_tracker tracker = new();
  int unsigned   cycles;
  int unsigned   burst_left;
  int unsigned   stall_left;
  int unsigned   stall_mode;
  int unsigned   sent;

  polyline_smooth_vertex_normals i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .last_point_i  (last_point_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .vertex_x_o    (vertex_x_o),
    .vertex_y_o    (vertex_y_o),
    .normal_x_o    (normal_x_o),
    .normal_y_o    (normal_y_o),
    .last_vertex_o (last_vertex_o),
    .overflow_o    (overflow_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stalls: stretches of always ready, random, and long stalls
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(1, 60);
    end
    stall_left--;
    case (stall_mode)
      0, 1: begin
        out_ready_i <= 1'b1;
      end
      2: begin
        out_ready_i <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_ready_i <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  always @(negedge clk_i) begin
    vertex_t act;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act.vx   = vertex_x_o;
      act.vy   = vertex_y_o;
      act.nx   = normal_x_o;
      act.ny   = normal_y_o;
      act.last = last_vertex_o;
      act.ovf  = overflow_o;
      tracker.check_vertex(act);
    end
  end

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, logic last);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    point_x_i    <= x;
    point_y_i    <= y;
    last_point_i <= last;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
    end
    @(posedge clk_i);
    tracker.take_point(x, y, last);
    sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_closed(logic v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.closed = v;
    @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord(int unsigned style);
    case (style)
      0: return $signed($urandom_range(0, 2097151)) - 1048576;
      1: return $urandom();
      default: return $signed($urandom_range(0, 7)) <<< 16;
    endcase
  endfunction

  task automatic send_run(int unsigned n, int unsigned style);
    for (int unsigned i = 0; i < n; i++)
      send_point(rand_coord(style), rand_coord(style), i == n - 1);
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= 1'b0;
    in_valid_i   <= 1'b0;
    point_x_i    <= '0;
    point_y_i    <= '0;
    last_point_i <= 1'b0;
    out_ready_i  <= 1'b0;
    tracker.closed = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single point, open
    send_point(32'sh7fffffff, 32'sh80000000, 1'b1);
    // two points, open then closed
    send_point(0, 0, 1'b0);
    send_point(32'sh00010000, 0, 1'b1);
    set_closed(1'b1);
    send_point(0, 0, 1'b0);
    send_point(0, 32'sh00010000, 1'b1);
    // coincident points
    send_point(32'sh00050000, 32'sh00050000, 1'b0);
    send_point(32'sh00050000, 32'sh00050000, 1'b0);
    send_point(32'sh00050000, 32'sh00050000, 1'b1);
    // coordinate extremes, closed then open
    send_point(32'sh7fffffff, 32'sh80000000, 1'b0);
    send_point(32'sh80000000, 32'sh7fffffff, 1'b0);
    send_point(32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_point(32'sh80000000, 32'sh80000000, 1'b1);
    set_closed(1'b0);
    send_point(32'sh7fffffff, 32'sh80000000, 1'b0);
    send_point(32'sh80000000, 32'sh7fffffff, 1'b0);
    send_point(-1, 1, 1'b0);
    send_point(32'sh80000000, 32'sh80000000, 1'b1);
    // full store: extra points and the flagged last point are dropped
    send_run(psvn_pkg::MaxPoints + 3, 0);
    set_closed(1'b1);
    send_run(psvn_pkg::MaxPoints, 1);

    while (sent < RandPoints) begin
      if ($urandom_range(0, 3) == 0) set_closed(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 11) == 0)
        send_run($urandom_range(40, psvn_pkg::MaxPoints + 3), $urandom_range(0, 2));
      else
        send_run($urandom_range(1, 8), $urandom_range(0, 2));
    end

    wait_idle();
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
